// File: rtl/core/bte_pkg.sv
// bte_pkg: shared types, mode codes, character constants and lookup functions
// for the byte-to-text encoder. No dependencies.
`timescale 1ns / 1ps

package bte_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_MODE = 1'b0;   // register index, taken from paddr[2]

    // queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // mode codes
    localparam logic [2:0] MODE_HEX_UPPER     = 3'd0;
    localparam logic [2:0] MODE_HEX_LOWER     = 3'd1;
    localparam logic [2:0] MODE_PCT_UPPER     = 3'd2;
    localparam logic [2:0] MODE_PCT_LOWER     = 3'd3;
    localparam logic [2:0] MODE_B64_PAD       = 3'd4;
    localparam logic [2:0] MODE_B64_NOPAD     = 3'd5;
    localparam logic [2:0] MODE_B64_URL_PAD   = 3'd6;
    localparam logic [2:0] MODE_B64_URL_NOPAD = 3'd7;

    // base64 group positions
    localparam logic [1:0] GP_FIRST  = 2'd0;
    localparam logic [1:0] GP_SECOND = 2'd1;
    localparam logic [1:0] GP_THIRD  = 2'd2;

    // characters
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_out;
        logic       end_of_message;
    } t_out_item;

    // all characters one byte produces, plus where they end
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            eom;
    } t_group;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = {4'b0, nib} + 8'h30;
        end else if (lower) begin
            r = {4'b0, nib} + 8'h57;
        end else begin
            r = {4'b0, nib} + 8'h37;
        end
        return r;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v, input logic url);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = {2'b0, v} + 8'h41;
        end else if (v < 6'd52) begin
            r = {2'b0, v} + 8'h47;
        end else if (v < 6'd62) begin
            r = {2'b0, v} - 8'd4;
        end else if (v == 6'd62) begin
            r = url ? CH_DASH : CH_PLUS;
        end else begin
            r = url ? CH_UNDER : CH_SLASH;
        end
        return r;
    endfunction

    function automatic logic is_plain(input logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                          CH_DASH, CH_UNDER, CH_DOT, CH_TILDE});
    endfunction

endpackage

// File: rtl/core/bte_front.sv
// bte_front: accepts input bytes, keeps the base64 group state and builds
// the full character group of each byte. Depends on bte_pkg.
`timescale 1ns / 1ps

module bte_front
    import bte_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic [2:0] i_mode,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_stall,
    input  logic     i_full,
    output logic     o_push,
    output t_group   o_group
);

    logic [1:0] r_gp;
    logic [3:0] r_held;
    logic [1:0] n_gp;
    logic [3:0] n_held;
    logic       w_accept;
    logic       w_lower;
    logic       w_pad;
    logic       w_url;
    logic [7:0] w_b;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    assign w_b     = i_data.in_byte;
    assign w_lower = i_mode[0];
    assign w_pad   = !i_mode[0];
    assign w_url   = i_mode[1];

    always_comb begin
        o_group.chars    = '0;
        o_group.last_idx = 2'd0;
        o_group.eom      = i_data.last_in;
        n_gp             = GP_FIRST;
        n_held           = 4'd0;
        if (!i_mode[2]) begin
            if (i_mode[1] && is_plain(w_b)) begin
                o_group.chars[0] = w_b;
            end else if (i_mode[1]) begin
                o_group.chars[0] = CH_PCT;
                o_group.chars[1] = hex_char(w_b[7:4], w_lower);
                o_group.chars[2] = hex_char(w_b[3:0], w_lower);
                o_group.last_idx = 2'd2;
            end else begin
                o_group.chars[0] = hex_char(w_b[7:4], w_lower);
                o_group.chars[1] = hex_char(w_b[3:0], w_lower);
                o_group.last_idx = 2'd1;
            end
        end else begin
            case (r_gp)
                GP_SECOND: begin
                    o_group.chars[0] = b64_char({r_held[1:0], w_b[7:4]}, w_url);
                    if (i_data.last_in) begin
                        o_group.chars[1] = b64_char({w_b[3:0], 2'b00}, w_url);
                        o_group.chars[2] = CH_EQ;
                        o_group.last_idx = w_pad ? 2'd2 : 2'd1;
                    end else begin
                        n_gp   = GP_THIRD;
                        n_held = w_b[3:0];
                    end
                end
                GP_THIRD: begin
                    o_group.chars[0] = b64_char({r_held, w_b[7:6]}, w_url);
                    o_group.chars[1] = b64_char(w_b[5:0], w_url);
                    o_group.last_idx = 2'd1;
                end
                default: begin
                    // position three cannot arise and acts as the first
                    o_group.chars[0] = b64_char(w_b[7:2], w_url);
                    if (i_data.last_in) begin
                        o_group.chars[1] = b64_char({w_b[1:0], 4'b0000}, w_url);
                        o_group.chars[2] = CH_EQ;
                        o_group.chars[3] = CH_EQ;
                        o_group.last_idx = w_pad ? 2'd3 : 2'd1;
                    end else begin
                        n_gp   = GP_SECOND;
                        n_held = {2'b00, w_b[1:0]};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp   <= GP_FIRST;
            r_held <= 4'd0;
        end else if (w_accept) begin
            r_gp   <= n_gp;
            r_held <= n_held;
        end
    end

    a_text_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_mode[2]) |=> (r_gp == GP_FIRST && r_held == 4'd0))
        else $error("group state not cleared after hex or percent beat");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.last_in) |=> (r_gp == GP_FIRST && r_held == 4'd0))
        else $error("group state not cleared after last beat");

    a_gp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gp != 2'd3) && (r_gp == GP_THIRD || r_held[3:2] == 2'b00))
        else $error("group position or held bits out of range");

endmodule

// File: rtl/core/bte_queue.sv
// bte_queue: short flip-flop queue of character groups between the front
// and the back. Depends on bte_pkg.
`timescale 1ns / 1ps

module bte_queue
    import bte_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output t_group o_head,
    output logic   o_full,
    output logic   o_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_group           r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/bte_back.sv
// bte_back: walks the head group into the output register one character per
// cycle while the output is not stalled. Depends on bte_pkg.
`timescale 1ns / 1ps

module bte_back
    import bte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_group    i_head,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    logic       r_valid;
    t_out_item  r_data;
    logic [1:0] r_idx;
    logic       n_valid;
    logic [1:0] n_idx;
    logic       w_load;
    logic       w_cur_last;

    // a new character may enter when the output register is free or drains
    assign w_load     = !i_empty && (!r_valid || !i_stall);
    assign w_cur_last = (r_idx == i_head.last_idx);
    assign o_pop      = w_load && w_cur_last;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (w_load) begin
            n_valid = 1'b1;
            n_idx   = w_cur_last ? 2'd0 : r_idx + 2'd1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data.out_char       <= i_head.chars[r_idx];
            r_data.last_out       <= w_cur_last;
            r_data.end_of_message <= w_cur_last && i_head.eom;
        end
    end

endmodule

// File: rtl/core/byte_to_text_encoder.sv
// byte_to_text_encoder: top level with the mode register and its APB port,
// joining bte_front, bte_queue and bte_back. Depends on bte_pkg.
`timescale 1ns / 1ps

// Each input beat carries one message byte and a last flag; the block emits
// one output beat per text character. Mode 0/1 give two hex digits (upper or
// lower case), mode 2/3 percent-encode (letters, digits and - _ . ~ pass
// through, anything else becomes % and two hex digits), modes 4 to 7 give
// base64 (standard or URL alphabet, padded or not), with the leftover bits
// and padding flushed on the last byte. A byte yields one to four
// characters; last_out marks the final character of a byte and
// end_of_message the final character of a byte flagged last. The front
// builds each byte's whole character group in the cycle it is taken; the
// back shifts one character per cycle, while the output is not stalled,
// out of a registered output. The queue of QUEUE_DEPTH groups lets input
// keep flowing while output is stalled. Write the mode register (address 0)
// only while no beat is in flight.

module byte_to_text_encoder
    import bte_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_in_item              i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_out_item             o_data,
    input  logic                  i_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [2:0] r_mode;
    logic       w_full;
    logic       w_empty;
    logic       w_push;
    logic       w_pop;
    t_group     w_group;
    t_group     w_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {{(CFG_DATA_W-3){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEX_UPPER;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
            r_mode <= pwdata[2:0];
        end
    end

    bte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_group (w_group)
    );

    bte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_group),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    bte_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// File: tb/sv/testbench.sv
// testbench for byte_to_text_encoder: drives random and directed byte beats in every mode,
// predicts the text characters in a small scoreboard class and checks each output beat.
// depends on bte_pkg and the byte_to_text_encoder rtl.
`timescale 1ns / 1ps

module testbench;
    import bte_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] MODE_REG_ADDR = {REG_MODE, 2'b00};
    localparam int HOLD_CYCLES = 60;
    localparam int PHASES = 16;
    localparam int PHASE_BYTES = 7;

    class encoded_text_board;
        logic [2:0] mode;
        logic [1:0] grp_pos;
        logic [3:0] held;
        t_out_item  due_chars[$];
        int         fails;
        string      hex_up = "0123456789ABCDEF";
        string      hex_lo = "0123456789abcdef";
        string      b64_set =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

        function new();
            mode = MODE_HEX_UPPER;
            grp_pos = GP_FIRST;
            held = '0;
            fails = 0;
        endfunction

        function logic [7:0] hex_digit(input logic [3:0] nib, input bit lower);
            return lower ? hex_lo[nib] : hex_up[nib];
        endfunction

        function logic [7:0] sym(input logic [5:0] v, input bit url);
            logic [7:0] ch;
            ch = b64_set[v];
            if (!url && ch == CH_DASH) begin
                ch = CH_PLUS;
            end else if (!url && ch == CH_UNDER) begin
                ch = CH_SLASH;
            end
            return ch;
        endfunction

        function bit plain(input logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                   (b >= "0" && b <= "9") || b == CH_DASH || b == CH_UNDER ||
                   b == CH_DOT || b == CH_TILDE;
        endfunction

        // predicts the characters one accepted byte beat yields
        function void take_byte(input t_in_item it);
            logic [7:0] chars[$];
            logic [7:0] b;
            bit         pad;
            bit         url;
            t_out_item  c;
            b = it.in_byte;
            if (mode <= MODE_PCT_LOWER) begin
                if (mode >= MODE_PCT_UPPER && plain(b)) begin
                    chars.push_back(b);
                end else begin
                    if (mode >= MODE_PCT_UPPER) begin
                        chars.push_back(CH_PCT);
                    end
                    chars.push_back(hex_digit(b[7:4], mode[0]));
                    chars.push_back(hex_digit(b[3:0], mode[0]));
                end
                grp_pos = GP_FIRST;
                held = '0;
            end else begin
                pad = !mode[0];
                url = mode >= MODE_B64_URL_PAD;
                case (grp_pos)
                    GP_SECOND: begin
                        chars.push_back(sym({held[1:0], b[7:4]}, url));
                        held = b[3:0];
                        grp_pos = GP_THIRD;
                    end
                    GP_THIRD: begin
                        chars.push_back(sym({held, b[7:6]}, url));
                        chars.push_back(sym(b[5:0], url));
                        held = '0;
                        grp_pos = GP_FIRST;
                    end
                    default: begin
                        chars.push_back(sym(b[7:2], url));
                        held = {2'b00, b[1:0]};
                        grp_pos = GP_SECOND;
                    end
                endcase
                if (it.last_in) begin
                    // flush leftover bits, and in padded modes pad to a full quad
                    if (grp_pos == GP_SECOND) begin
                        chars.push_back(sym({held[1:0], 4'b0000}, url));
                        if (pad) begin
                            chars.push_back(CH_EQ);
                            chars.push_back(CH_EQ);
                        end
                    end else if (grp_pos == GP_THIRD) begin
                        chars.push_back(sym({held, 2'b00}, url));
                        if (pad) begin
                            chars.push_back(CH_EQ);
                        end
                    end
                    grp_pos = GP_FIRST;
                    held = '0;
                end
            end
            foreach (chars[k]) begin
                c.out_char = chars[k];
                c.last_out = (k == chars.size() - 1);
                c.end_of_message = (k == chars.size() - 1) && it.last_in;
                due_chars.push_back(c);
            end
        endfunction

        function void check_char(input t_out_item got);
            t_out_item want;
            if (due_chars.size() == 0) begin
                $error("out_char unexpected beat, got %h", got.out_char);
                fails++;
                return;
            end
            want = due_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                $error("out_char expected %h actual %h", want.out_char, got.out_char);
                fails++;
            end
            if (got.last_out !== want.last_out) begin
                $error("last_out expected %b actual %b", want.last_out, got.last_out);
                fails++;
            end
            if (got.end_of_message !== want.end_of_message) begin
                $error("end_of_message expected %b actual %b",
                       want.end_of_message, got.end_of_message);
                fails++;
            end
        endfunction
    endclass

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] b;
        logic       last;
    } t_directed;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_in_item              i_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out_item             o_data;
    logic                  i_stall = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    encoded_text_board text_board = new();
    bit hold_request = 1'b0;
    int tx_calm = 0;

    // hex, percent pass-through and escapes, full and partial base64 groups,
    // and a mode change in the middle of a url group
    t_directed directed [22] = '{
        '{MODE_HEX_UPPER,     8'h00, 1'b0},
        '{MODE_HEX_UPPER,     8'hFF, 1'b1},
        '{MODE_HEX_LOWER,     8'hAB, 1'b1},
        '{MODE_PCT_UPPER,     "a",   1'b0},
        '{MODE_PCT_UPPER,     "Z",   1'b0},
        '{MODE_PCT_UPPER,     "~",   1'b0},
        '{MODE_PCT_UPPER,     8'h2F, 1'b0},
        '{MODE_PCT_UPPER,     8'hFE, 1'b0},
        '{MODE_PCT_LOWER,     "0",   1'b0},
        '{MODE_PCT_LOWER,     "-",   1'b0},
        '{MODE_PCT_LOWER,     "_",   1'b0},
        '{MODE_PCT_LOWER,     ".",   1'b0},
        '{MODE_PCT_LOWER,     8'hC3, 1'b1},
        '{MODE_B64_PAD,       8'hFB, 1'b0},
        '{MODE_B64_PAD,       8'hEF, 1'b0},
        '{MODE_B64_PAD,       8'hFF, 1'b0},
        '{MODE_B64_PAD,       8'h4D, 1'b1},
        '{MODE_B64_NOPAD,     8'h00, 1'b0},
        '{MODE_B64_NOPAD,     8'h01, 1'b1},
        '{MODE_B64_URL_PAD,   8'hFB, 1'b0},
        '{MODE_B64_URL_NOPAD, 8'hFF, 1'b0},
        '{MODE_B64_URL_NOPAD, 8'hF0, 1'b1}
    };

    byte_to_text_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_byte(input t_in_item it);
        int gap;
        if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            tx_calm = 15;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 4);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        text_board.take_byte(it);
    endtask

    // mode is only written once every predicted character has come out
    task automatic set_mode(input logic [2:0] m);
        i_valid <= 1'b0;
        while (text_board.due_chars.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MODE_REG_ADDR;
        pwdata <= CFG_DATA_W'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        text_board.mode = m;
    endtask

    function automatic logic [7:0] pick_byte();
        string plain_set;
        plain_set = "azAZ09-_.~";
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(8'h20, 8'h7E));
            1: return plain_set[$urandom_range(0, plain_set.len() - 1)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // output side: random stall before each beat, one long hold on request
    initial begin
        int w;
        int calm;
        calm = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                w = HOLD_CYCLES;
            end else if (calm > 0) begin
                calm--;
                w = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                calm = 15;
                w = 0;
            end else begin
                w = $urandom_range(0, 4);
            end
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
            text_board.check_char(o_data);
        end
    end

    initial begin
        t_in_item   it;
        logic [2:0] cur;
        int         base;
        int         msg_left;
        int         p;
        int         n;
        cur = MODE_HEX_UPPER;
        msg_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (k == 0 || directed[k].mode != cur) begin
                cur = directed[k].mode;
                set_mode(cur);
            end
            it.in_byte = directed[k].b;
            it.last_in = directed[k].last;
            send_byte(it);
        end

        // first eight phases visit every mode, the rest pick at random;
        // messages run across phase borders so groups get cut by mode writes
        base = $urandom_range(0, 7);
        for (p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                cur = 3'((base + p) % 8);
            end else begin
                cur = 3'($urandom_range(0, 7));
            end
            set_mode(cur);
            if (p == 3) begin
                hold_request = 1'b1;
            end
            for (n = 0; n < PHASE_BYTES; n++) begin
                if (msg_left == 0) begin
                    msg_left = $urandom_range(1, 5);
                end
                it.in_byte = pick_byte();
                it.last_in = (msg_left == 1);
                msg_left--;
                send_byte(it);
            end
        end

        i_valid <= 1'b0;
        while (text_board.due_chars.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (text_board.fails == 0 && text_board.due_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bte_pkg.sv
rtl/core/bte_front.sv
rtl/core/bte_queue.sv
rtl/core/bte_back.sv
rtl/core/byte_to_text_encoder.sv
tb/sv/testbench.sv
